[rtl/core/gdd_pkg.sv]
`default_nettype none
package gdd_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned COUNT_W = 23;
  localparam int unsigned DOY_W   = 9;
  localparam int unsigned DBY_W   = 23;
  localparam int unsigned QUAD_W  = YEAR_W - 2;
  localparam int unsigned PROD_W  = 23;
  localparam int unsigned SUM_W   = 25;

  localparam logic [YEAR_W-1:0]  MAX_YEAR   = YEAR_W'(9999);
  localparam logic [PROD_W-1:0]  RECIP25    = PROD_W'(1311);
  localparam int unsigned        RECIP_SH   = 15;
  localparam logic [PROD_W-1:0]  YEAR_DAYS  = PROD_W'(365);
  localparam logic [QUAD_W-1:0]  CENT_QUADS = QUAD_W'(25);

  localparam logic [MONTH_W-1:0] JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MAR = MONTH_W'(3);
  localparam logic [MONTH_W-1:0] APR = MONTH_W'(4);
  localparam logic [MONTH_W-1:0] MAY = MONTH_W'(5);
  localparam logic [MONTH_W-1:0] JUN = MONTH_W'(6);
  localparam logic [MONTH_W-1:0] JUL = MONTH_W'(7);
  localparam logic [MONTH_W-1:0] AUG = MONTH_W'(8);
  localparam logic [MONTH_W-1:0] SEP = MONTH_W'(9);
  localparam logic [MONTH_W-1:0] OCT = MONTH_W'(10);
  localparam logic [MONTH_W-1:0] NOV = MONTH_W'(11);
  localparam logic [MONTH_W-1:0] DEC = MONTH_W'(12);

  localparam logic signed [SUM_W-1:0] COUNT_MAX = SUM_W'(4194303);
  localparam logic signed [SUM_W-1:0] COUNT_MIN = -SUM_W'(4194304);

  typedef struct packed {
    logic               ok;
    logic [DOY_W-1:0]   doy;
    logic [DBY_W-1:0]   dby;
  } date_info_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] n;
    unique case (m)
      FEB:                n = leap ? DAY_W'(29) : DAY_W'(28);
      APR, JUN, SEP, NOV: n = DAY_W'(30);
      default:            n = DAY_W'(31);
    endcase
    return n;
  endfunction

  function automatic logic [DOY_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] n;
    unique case (m)
      JAN:     n = DOY_W'(0);
      FEB:     n = DOY_W'(31);
      MAR:     n = DOY_W'(59);
      APR:     n = DOY_W'(90);
      MAY:     n = DOY_W'(120);
      JUN:     n = DOY_W'(151);
      JUL:     n = DOY_W'(181);
      AUG:     n = DOY_W'(212);
      SEP:     n = DOY_W'(243);
      OCT:     n = DOY_W'(273);
      NOV:     n = DOY_W'(304);
      DEC:     n = DOY_W'(334);
      default: n = DOY_W'(0);
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

[rtl/core/gdd_in_if.sv]
`default_nettype none
interface gdd_in_if;
  logic                         valid;
  logic                         ready;
  logic [gdd_pkg::DAY_W-1:0]    first_day;
  logic [gdd_pkg::MONTH_W-1:0]  first_month;
  logic [gdd_pkg::YEAR_W-1:0]   first_year;
  logic [gdd_pkg::DAY_W-1:0]    second_day;
  logic [gdd_pkg::MONTH_W-1:0]  second_month;
  logic [gdd_pkg::YEAR_W-1:0]   second_year;

  modport source (
    output valid, first_day, first_month, first_year,
           second_day, second_month, second_year,
    input  ready
  );
  modport sink (
    input  valid, first_day, first_month, first_year,
           second_day, second_month, second_year,
    output ready
  );
endinterface
`default_nettype wire

[rtl/core/gdd_out_if.sv]
`default_nettype none
interface gdd_out_if;
  logic                                valid;
  logic                                ready;
  logic                                first_valid;
  logic                                second_valid;
  logic signed [gdd_pkg::COUNT_W-1:0]  day_count;

  modport source (
    output valid, first_valid, second_valid, day_count,
    input  ready
  );
  modport sink (
    input  valid, first_valid, second_valid, day_count,
    output ready
  );
endinterface
`default_nettype wire

[rtl/core/gdd_date_unit.sv]
`default_nettype none
module gdd_date_unit (
  input  wire logic                          clk,
  input  wire logic                          advance,
  input  wire logic [gdd_pkg::DAY_W-1:0]     day,
  input  wire logic [gdd_pkg::MONTH_W-1:0]   month,
  input  wire logic [gdd_pkg::YEAR_W-1:0]    year,
  output gdd_pkg::date_info_t                info
);

  localparam int unsigned QW = gdd_pkg::QUAD_W;
  localparam int unsigned PW = gdd_pkg::PROD_W;

  logic [gdd_pkg::YEAR_W-1:0]  prev_year;

  logic [gdd_pkg::DAY_W-1:0]   s1_day;
  logic [gdd_pkg::MONTH_W-1:0] s1_month;
  logic                        s1_range_ok;
  logic                        s1_quad;
  logic [QW-1:0]               s1_qy;
  logic [PW-1:0]               s1_my;
  logic [QW-1:0]               s1_qp;
  logic [PW-1:0]               s1_mp;
  logic [PW-1:0]               s1_p365;

  logic [gdd_pkg::DAY_W-1:0]   s2_day;
  logic [gdd_pkg::MONTH_W-1:0] s2_month;
  logic                        s2_range_ok;
  logic                        s2_leap;
  logic [gdd_pkg::DBY_W-1:0]   s2_dby;

  logic [QW-1:0]               cent_y;
  logic [QW-1:0]               cent_p;
  logic [QW-1:0]               rem_y;
  logic                        leap_next;
  logic [gdd_pkg::DBY_W-1:0]   dby_next;
  logic [gdd_pkg::DAY_W-1:0]   mlen;
  logic                        ok_next;
  logic [gdd_pkg::DOY_W-1:0]   doy_next;

  assign prev_year = year - gdd_pkg::YEAR_W'(1);

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_day      <= day;
      s1_month    <= month;
      s1_range_ok <= (month >= gdd_pkg::JAN) && (month <= gdd_pkg::DEC) &&
                     (year != '0) && (year <= gdd_pkg::MAX_YEAR);
      s1_quad     <= (year[1:0] == 2'b00);
      s1_qy       <= year[gdd_pkg::YEAR_W-1:2];
      s1_my       <= PW'(year[gdd_pkg::YEAR_W-1:2]) * gdd_pkg::RECIP25;
      s1_qp       <= prev_year[gdd_pkg::YEAR_W-1:2];
      s1_mp       <= PW'(prev_year[gdd_pkg::YEAR_W-1:2]) * gdd_pkg::RECIP25;
      s1_p365     <= PW'(prev_year) * gdd_pkg::YEAR_DAYS;
    end
  end

  // quads / 25 gives centuries; low two bits of that flag the 400-year cycle
  assign cent_y    = QW'(s1_my >> gdd_pkg::RECIP_SH);
  assign cent_p    = QW'(s1_mp >> gdd_pkg::RECIP_SH);
  assign rem_y     = s1_qy - QW'(cent_y * gdd_pkg::CENT_QUADS);
  assign leap_next = s1_quad && ((rem_y != '0) || (cent_y[1:0] == 2'b00));
  assign dby_next  = s1_p365 + gdd_pkg::DBY_W'(s1_qp) - gdd_pkg::DBY_W'(cent_p)
                     + gdd_pkg::DBY_W'(cent_p >> 2);

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_day      <= s1_day;
      s2_month    <= s1_month;
      s2_range_ok <= s1_range_ok;
      s2_leap     <= leap_next;
      s2_dby      <= dby_next;
    end
  end

  assign mlen     = gdd_pkg::month_len(s2_month, s2_leap);
  assign ok_next  = s2_range_ok && (s2_day != '0) && (s2_day <= mlen);
  assign doy_next = gdd_pkg::days_before_month(s2_month) + gdd_pkg::DOY_W'(s2_day)
                    + gdd_pkg::DOY_W'(s2_leap && (s2_month > gdd_pkg::FEB));

  always_ff @(posedge clk) begin
    if (advance) begin
      info.ok  <= ok_next;
      info.doy <= doy_next;
      info.dby <= s2_dby;
    end
  end

endmodule
`default_nettype wire

[rtl/core/gregorian_date_difference.sv]
`default_nettype none
// Day count between two Gregorian dates. Each beat on dates carries two
// dates; each beat on result gives a valid flag per date and the signed day
// count from the first date to the second (0 when either date is invalid,
// year span ignored when the second year is not later). A four-stage
// pipeline: a new beat can enter every cycle unless result is stalled.
// Leap and century tests use constant reciprocal multiplies in the first
// stage; when result is stalled the whole pipeline holds, and dates.ready
// drops whenever a finished result waits on result.
module gregorian_date_difference (
  input  wire logic  clk,
  input  wire logic  rst,
  gdd_in_if.sink     dates,
  gdd_out_if.source  result
);

  localparam int unsigned SW = gdd_pkg::SUM_W;

  logic                advance;
  logic [2:0]          stage_valid;
  logic [2:0]          later;
  gdd_pkg::date_info_t info_a;
  gdd_pkg::date_info_t info_b;
  logic signed [SW-1:0] span;
  logic signed [SW-1:0] count_raw;
  logic signed [SW-1:0] count_sat;

  assign advance     = !result.valid || result.ready;
  assign dates.ready = advance;

  gdd_date_unit u_first (
    .clk     (clk),
    .advance (advance),
    .day     (dates.first_day),
    .month   (dates.first_month),
    .year    (dates.first_year),
    .info    (info_a)
  );

  gdd_date_unit u_second (
    .clk     (clk),
    .advance (advance),
    .day     (dates.second_day),
    .month   (dates.second_month),
    .year    (dates.second_year),
    .info    (info_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= '0;
      result.valid <= 1'b0;
    end else if (advance) begin
      stage_valid  <= {stage_valid[1:0], dates.valid};
      result.valid <= stage_valid[2];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      later <= {later[1:0], dates.second_year > dates.first_year};
    end
  end

  assign span      = later[2] ? (SW'(signed'({1'b0, info_b.dby})) -
                                 SW'(signed'({1'b0, info_a.dby})))
                              : '0;
  assign count_raw = span - SW'(signed'({1'b0, info_a.doy}))
                          + SW'(signed'({1'b0, info_b.doy}));

  always_comb begin
    priority if (!(info_a.ok && info_b.ok)) begin
      count_sat = '0;
    end else if (count_raw > gdd_pkg::COUNT_MAX) begin
      count_sat = gdd_pkg::COUNT_MAX;
    end else if (count_raw < gdd_pkg::COUNT_MIN) begin
      count_sat = gdd_pkg::COUNT_MIN;
    end else begin
      count_sat = count_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.first_valid  <= info_a.ok;
      result.second_valid <= info_b.ok;
      result.day_count    <= count_sat[gdd_pkg::COUNT_W-1:0];
    end
  end

endmodule
`default_nettype wire

[dv/tb.sv]
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gdd_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 20;
  localparam int RANDOM_BEATS  = 80;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } date_t;

  typedef struct packed {
    logic                      first_valid;
    logic                      second_valid;
    logic signed [COUNT_W-1:0] day_count;
  } span_t;

  typedef struct {
    date_t first;
    date_t second;
    bit    known;
    span_t want;
  } date_row_t;

  logic clk;
  logic rst;

  gdd_in_if  dates_bus ();
  gdd_out_if result_bus ();

  gregorian_date_difference dut (
    .clk    (clk),
    .rst    (rst),
    .dates  (dates_bus),
    .result (result_bus)
  );

  date_row_t date_beats[$];
  span_t     span_expected[$];
  int        beats_accepted = 0;
  int        mismatches = 0;
  bit        hold_off = 1'b0;

  function automatic bit year_is_leap(longint y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int month_days(logic [MONTH_W-1:0] m, longint y);
    case (m)
      FEB:                return year_is_leap(y) ? 29 : 28;
      APR, JUN, SEP, NOV: return 30;
      default:            return 31;
    endcase
  endfunction

  function automatic bit date_is_valid(date_t dt);
    if (dt.month < JAN || dt.month > DEC) return 1'b0;
    if (dt.year < 1 || dt.year > MAX_YEAR) return 1'b0;
    return dt.day >= 1 && dt.day <= month_days(dt.month, dt.year);
  endfunction

  function automatic longint days_to_year(longint y);
    longint p;
    p = y - 1;
    return 365 * p + p / 4 - p / 100 + p / 400;
  endfunction

  function automatic longint ordinal_day(date_t dt);
    longint n;
    n = dt.day;
    for (int k = 1; k < dt.month; k++) n += month_days(MONTH_W'(k), dt.year);
    return n;
  endfunction

  function automatic span_t predict_span(date_t a, date_t b);
    span_t  s;
    longint n;
    s.first_valid  = date_is_valid(a);
    s.second_valid = date_is_valid(b);
    n = 0;
    if (s.first_valid && s.second_valid) begin
      if (b.year > a.year) n = days_to_year(b.year) - days_to_year(a.year);
      n = n - ordinal_day(a) + ordinal_day(b);
      if (n > 4194303) n = 4194303;
      if (n < -4194304) n = -4194304;
    end
    s.day_count = COUNT_W'(n);
    return s;
  endfunction

  function automatic void add_row(int d1, int m1, int y1, int d2, int m2, int y2,
                                  bit known = 1'b0, bit v1 = 1'b0, bit v2 = 1'b0,
                                  int cnt = 0);
    date_row_t r;
    r.first          = '{DAY_W'(d1), MONTH_W'(m1), YEAR_W'(y1)};
    r.second         = '{DAY_W'(d2), MONTH_W'(m2), YEAR_W'(y2)};
    r.known          = known;
    r.want           = '{v1, v2, COUNT_W'(cnt)};
    date_beats.push_back(r);
  endfunction

  function automatic date_t random_valid_date(longint near_year, bit use_near);
    date_t  dt;
    longint y;
    case ($urandom_range(0, 5))
      0:       y = 1;
      1:       y = MAX_YEAR;
      default: y = $urandom_range(1, MAX_YEAR);
    endcase
    if (use_near) begin
      y = near_year + $signed($urandom_range(0, 6)) - 3;
      if (y < 1) y = 1;
      if (y > MAX_YEAR) y = MAX_YEAR;
    end
    dt.year  = YEAR_W'(y);
    dt.month = MONTH_W'($urandom_range(JAN, DEC));
    dt.day   = DAY_W'($urandom_range(1, month_days(dt.month, y)));
    return dt;
  endfunction

  function automatic date_t random_noise_date();
    date_t dt;
    dt.day   = DAY_W'($urandom());
    dt.month = MONTH_W'($urandom());
    dt.year  = YEAR_W'($urandom());
    return dt;
  endfunction

  function automatic date_t random_date(longint near_year);
    date_t dt;
    int    pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      dt = random_valid_date(near_year, pick < 3);
    end else if (pick < 9) begin
      dt = random_noise_date();
    end else begin
      dt = random_valid_date(near_year, 1'b0);
      dt.day = DAY_W'(month_days(dt.month, dt.year) + 1);
    end
    return dt;
  endfunction

  function automatic void build_stimulus();
    date_row_t r;
    add_row(1, JAN, 1, 1, JAN, 1, 1, 1, 1, 0);
    add_row(1, JAN, 1, 1, JAN, 2, 1, 1, 1, 365);
    add_row(31, DEC, 9999, 31, DEC, 9999, 1, 1, 1, 0);
    add_row(1, JAN, 1, 31, DEC, 9999);
    add_row(31, DEC, 9999, 1, JAN, 1, 1, 1, 1, -364);
    add_row(31, DEC, 2000, 1, JAN, 1999, 1, 1, 1, -365);
    add_row(0, JAN, 2000, 1, JAN, 2000, 1, 0, 1, 0);
    add_row(1, JAN, 2000, 31, 0, 2000, 1, 1, 0, 0);
    add_row(1, 13, 2000, 1, 15, 2000, 1, 0, 0, 0);
    add_row(1, JAN, 0, 1, JAN, 10000, 1, 0, 0, 0);
    add_row(31, DEC, 16383, 1, JAN, 9999, 1, 0, 1, 0);
    add_row(29, FEB, 2000, 29, FEB, 1900, 1, 1, 0, 0);
    add_row(29, FEB, 2004, 29, FEB, 2001, 1, 1, 0, 0);
    add_row(28, FEB, 1900, 29, FEB, 2400);
    add_row(31, APR, 2021, 30, APR, 2021, 1, 0, 1, 0);
    add_row(31, JUN, 2021, 31, SEP, 2021, 1, 0, 0, 0);
    add_row(31, NOV, 2021, 30, NOV, 2021, 1, 0, 1, 0);
    add_row(31, JAN, 1999, 31, MAR, 2024);
    add_row(31, MAY, 1600, 31, JUL, 1700);
    add_row(31, AUG, 1, 31, OCT, 9998);
    add_row(15, MAR, 2024, 15, MAR, 2023);
    add_row(31, 15, 16383, 31, 15, 16383, 1, 0, 0, 0);
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      r.first  = random_date($urandom_range(1, MAX_YEAR));
      r.second = random_date(r.first.year);
      r.known  = 1'b0;
      r.want   = '0;
      date_beats.push_back(r);
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    date_row_t row;
    int        burst;
    int        gap;
    rst                    <= 1'b1;
    dates_bus.valid        <= 1'b0;
    dates_bus.first_day    <= '0;
    dates_bus.first_month  <= '0;
    dates_bus.first_year   <= '0;
    dates_bus.second_day   <= '0;
    dates_bus.second_month <= '0;
    dates_bus.second_year  <= '0;
    build_stimulus();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    burst = $urandom_range(1, 12);
    foreach (date_beats[i]) begin
      row = date_beats[i];
      dates_bus.valid        <= 1'b1;
      dates_bus.first_day    <= row.first.day;
      dates_bus.first_month  <= row.first.month;
      dates_bus.first_year   <= row.first.year;
      dates_bus.second_day   <= row.second.day;
      dates_bus.second_month <= row.second.month;
      dates_bus.second_year  <= row.second.year;
      do @(negedge clk); while (!dates_bus.ready);
      span_expected.push_back(row.known ? row.want : predict_span(row.first, row.second));
      beats_accepted++;
      @(posedge clk);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          dates_bus.valid        <= 1'b0;
          dates_bus.first_day    <= DAY_W'($urandom());
          dates_bus.first_month  <= MONTH_W'($urandom());
          dates_bus.first_year   <= YEAR_W'($urandom());
          dates_bus.second_day   <= DAY_W'($urandom());
          dates_bus.second_month <= MONTH_W'($urandom());
          dates_bus.second_year  <= YEAR_W'($urandom());
          repeat (gap) @(posedge clk);
        end
      end
    end
    dates_bus.valid <= 1'b0;
    while (span_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    int mode;
    int span;
    int tick;
    result_bus.ready <= 1'b0;
    wait (rst === 1'b0);
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 40);
      repeat (span) begin
        @(posedge clk);
        tick++;
        case (mode)
          0:       result_bus.ready <= !hold_off;
          1:       result_bus.ready <= !hold_off && $urandom_range(0, 1);
          2:       result_bus.ready <= !hold_off && (tick % 3 != 0);
          default: result_bus.ready <= !hold_off && ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  initial begin
    wait (beats_accepted >= 40);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_off = 1'b0;
  end

  always @(negedge clk) begin
    span_t got;
    span_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      got = '{result_bus.first_valid, result_bus.second_valid, result_bus.day_count};
      if (span_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result beat: fv=%0b sv=%0b count=%0d",
                   got.first_valid, got.second_valid, got.day_count);
      end else begin
        want = span_expected.pop_front();
        if (got.first_valid !== want.first_valid ||
            got.second_valid !== want.second_valid ||
            got.day_count !== want.day_count) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("mismatch: expected fv=%0b sv=%0b count=%0d, got fv=%0b sv=%0b count=%0d",
                     want.first_valid, want.second_valid, want.day_count,
                     got.first_valid, got.second_valid, got.day_count);
        end
      end
    end
  end

  initial begin
    #3ms;
    $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire
